/* hw/rtl/rlecsp_pkg.sv */
// ----------------------------------------------------------------------------
// rlecsp_pkg
// Types and constants shared by the run-length layer string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rlecsp_pkg;

  localparam int COUNT_W = 27;
  localparam int SIZE_W  = 25;
  localparam int DIGIT_W = 4;
  localparam int SYM_W   = 16;
  localparam int CHAR_W  = 8;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [DIGIT_W-1:0] DIGIT_CAP = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIGITS  = 2'd2;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_DIGITS    = 3'd1;
  localparam status_t ST_ZERO      = 3'd2;
  localparam status_t ST_OVER      = 3'd3;
  localparam status_t ST_SHORT     = 3'd4;
  localparam status_t ST_TRUNCATED = 3'd5;

  typedef struct packed {
    logic [COUNT_W-1:0] digit_value;
    logic [DIGIT_W-1:0] digit_count;
    logic [SIZE_W-1:0]  run_total;
    logic [CHAR_W-1:0]  first_char;
    logic               awaiting_second;
    logic               error_latched;
  } parse_state_t;

  typedef struct packed {
    logic               emit;
    logic               run_valid;
    logic [COUNT_W-1:0] run_count;
    logic [SYM_W-1:0]   symbol;
    status_t            status;
    logic               layer_end;
  } parse_result_t;

endpackage

`default_nettype wire

/* hw/rtl/rle_count_symbol_parser.sv */
// ----------------------------------------------------------------------------
// rle_count_symbol_parser
// Parses an ASCII run-length layer string into count and symbol runs.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle unless src_stall is high, and each
// is finished combinationally: the decimal multiply-add, the running-total
// add and compare all sit between the parser state registers and the result
// register. A result shows in the cycle after the character that causes it.
// The output register lets the next character in while a result waits to be
// taken, so src_stall rises only while a result is held and res_stall is
// high. Configuration writes are always ready and must be made while idle.
`default_nettype none

module rle_count_symbol_parser (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  src_valid,
  output logic                                  src_stall,
  input  logic [7:0]                            data_byte,
  input  logic                                  layer_last,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic                                  run_valid,
  output logic [26:0]                           run_count,
  output logic [15:0]                           symbol,
  output logic [2:0]                            status,
  output logic                                  layer_end,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rlecsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rlecsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                                 symbol_mode;
  logic [rlecsp_pkg::SIZE_W-1:0]        layer_cells;
  logic [rlecsp_pkg::DIGIT_W-1:0]       digit_max;
  rlecsp_pkg::parse_state_t             state;
  rlecsp_pkg::parse_state_t             state_next;
  rlecsp_pkg::parse_result_t            step_res;
  logic                                 src_take;
  logic                                 res_take;

  assign cfg_ready = 1'b1;
  assign src_stall = res_valid && res_stall;
  assign src_take  = src_valid && !src_stall;
  assign res_take  = res_valid && !res_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_mode <= 1'b0;
      layer_cells <= 25'd256;
      digit_max   <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rlecsp_pkg::REG_SYMBOL_MODE: symbol_mode <= cfg_data[0];
        rlecsp_pkg::REG_LAYER_SIZE:  layer_cells <= cfg_data[rlecsp_pkg::SIZE_W-1:0];
        rlecsp_pkg::REG_MAX_DIGITS:  digit_max   <= cfg_data[rlecsp_pkg::DIGIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rlecsp_step u_step (
    .state       (state),
    .symbol_mode (symbol_mode),
    .layer_cells (layer_cells),
    .digit_max   (digit_max),
    .data_byte   (data_byte),
    .layer_last  (layer_last),
    .state_next  (state_next),
    .result      (step_res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (src_take) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (src_take && step_res.emit) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take && step_res.emit) begin
      run_valid <= step_res.run_valid;
      run_count <= step_res.run_count;
      symbol    <= step_res.symbol;
      status    <= step_res.status;
      layer_end <= step_res.layer_end;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    src_take |-> !(res_valid && res_stall))
    else $error("result overwritten while held");

  a_run_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && run_valid |-> (status == rlecsp_pkg::ST_OK || status == rlecsp_pkg::ST_SHORT))
    else $error("run delivered with an error status");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && run_valid |-> run_count != '0)
    else $error("delivered run has zero count");

  a_end_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == rlecsp_pkg::ST_SHORT || status == rlecsp_pkg::ST_TRUNCATED)
    |-> layer_end)
    else $error("end-of-layer status without layer end");

  a_latched_quiet: assert property (@(posedge clk) disable iff (rst)
    src_take && state.error_latched && !layer_last |-> !step_res.emit)
    else $error("result emitted after a latched error");

  a_layer_clear: assert property (@(posedge clk) disable iff (rst)
    src_take && layer_last |=> state == '0)
    else $error("state not cleared at layer end");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rlecsp_step.sv */
// ----------------------------------------------------------------------------
// rlecsp_step
// Next parser state and result for one character of the layer string.
// ----------------------------------------------------------------------------
`default_nettype none

module rlecsp_step (
  input  rlecsp_pkg::parse_state_t              state,
  input  logic                                  symbol_mode,
  input  logic [rlecsp_pkg::SIZE_W-1:0]         layer_cells,
  input  logic [rlecsp_pkg::DIGIT_W-1:0]        digit_max,
  input  logic [rlecsp_pkg::CHAR_W-1:0]         data_byte,
  input  logic                                  layer_last,
  output rlecsp_pkg::parse_state_t              state_next,
  output rlecsp_pkg::parse_result_t             result
);

  logic [rlecsp_pkg::DIGIT_W-1:0] limit;
  logic                           is_digit;
  logic [rlecsp_pkg::COUNT_W-1:0] times_ten;
  logic [rlecsp_pkg::SIZE_W+2:0]  sum;
  logic                           over;

  assign limit     = (digit_max > rlecsp_pkg::DIGIT_CAP) ? rlecsp_pkg::DIGIT_CAP : digit_max;
  assign is_digit  = data_byte inside {[8'h30:8'h39]};
  assign times_ten = {state.digit_value[23:0], 3'b000} + {state.digit_value[25:0], 1'b0};
  assign sum       = {3'b000, state.run_total} + {1'b0, state.digit_value};
  assign over      = sum > {3'b000, layer_cells};

  always_comb begin
    rlecsp_pkg::parse_state_t nxt;
    logic                     ok;
    logic                     finish;
    logic [rlecsp_pkg::SYM_W-1:0] sym;
    rlecsp_pkg::status_t      st;

    nxt    = state;
    ok     = 1'b0;
    finish = 1'b0;
    sym    = '0;
    st     = rlecsp_pkg::ST_OK;

    if (state.error_latched) begin
      finish = 1'b0;
    end else if (state.awaiting_second) begin
      sym    = {state.first_char, data_byte};
      finish = 1'b1;
      nxt.awaiting_second = 1'b0;
      nxt.first_char      = '0;
    end else if (is_digit) begin
      if (state.digit_count >= limit) begin
        st = rlecsp_pkg::ST_DIGITS;
      end else begin
        nxt.digit_value = times_ten + {23'd0, data_byte[3:0]};
        nxt.digit_count = state.digit_count + 4'd1;
      end
    end else if (!symbol_mode) begin
      sym    = {8'h00, data_byte};
      finish = 1'b1;
    end else begin
      nxt.first_char      = data_byte;
      nxt.awaiting_second = 1'b1;
      if (layer_last) begin
        st = rlecsp_pkg::ST_TRUNCATED;
      end
    end

    if (finish) begin
      nxt.digit_value = '0;
      nxt.digit_count = '0;
      if (state.digit_value == '0) begin
        st = rlecsp_pkg::ST_ZERO;
      end else if (over) begin
        st = rlecsp_pkg::ST_OVER;
      end else begin
        nxt.run_total = sum[rlecsp_pkg::SIZE_W-1:0];
        ok            = 1'b1;
      end
    end

    result.run_valid = ok;
    result.run_count = ok ? state.digit_value : '0;
    result.symbol    = ok ? sym : '0;
    result.layer_end = layer_last;
    result.emit      = layer_last || (st != rlecsp_pkg::ST_OK) || ok;

    if (layer_last) begin
      if (st == rlecsp_pkg::ST_OK && !state.error_latched && nxt.run_total != layer_cells) begin
        st = rlecsp_pkg::ST_SHORT;
      end
      nxt = '0;
    end else if (st != rlecsp_pkg::ST_OK) begin
      nxt.error_latched   = 1'b1;
      nxt.digit_value     = '0;
      nxt.digit_count     = '0;
      nxt.awaiting_second = 1'b0;
      nxt.first_char      = '0;
    end

    result.status = st;
    state_next    = nxt;
  end

endmodule

`default_nettype wire

/* bench/rle_count_symbol_parser_tb.sv */
// ----------------------------------------------------------------------------
// rle_count_symbol_parser_tb
// Self-checking bench for the run-length layer string parser. A short
// directed script walks reset values, extremes and each error case. Random
// layer strings then run under several register settings. Checked script
// rows are held to listed values, the rest to the bench's behavioral parser.
// ----------------------------------------------------------------------------
module rle_count_symbol_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 225;

  typedef enum logic [1:0] {ROW_CHAR, ROW_CHECKED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                              kind;
    logic [rlecsp_pkg::CFG_IDX_W-1:0]       reg_idx;
    logic [rlecsp_pkg::CFG_DATA_W-1:0]      value;
    logic                                   last;
    logic                                   run_valid;
    logic [rlecsp_pkg::COUNT_W-1:0]         count;
    logic [rlecsp_pkg::SYM_W-1:0]           sym;
    rlecsp_pkg::status_t                    st;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  src_valid = 1'b0;
  logic                  src_stall;
  logic [7:0]            data_byte = 8'h00;
  logic                  layer_last = 1'b0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic                  run_valid;
  logic [26:0]           run_count;
  logic [15:0]           symbol;
  logic [2:0]            status;
  logic                  layer_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [rlecsp_pkg::CFG_IDX_W-1:0]  cfg_index = rlecsp_pkg::REG_SYMBOL_MODE;
  logic [rlecsp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // behavioral parser: registers and per-layer state
  logic                             mode_sel = 1'b0;
  logic [rlecsp_pkg::SIZE_W-1:0]    layer_cells = 25'd256;
  logic [rlecsp_pkg::DIGIT_W-1:0]   digit_limit = 4'd3;
  rlecsp_pkg::parse_state_t         parser = '0;

  rlecsp_pkg::parse_result_t pending_runs[$];
  logic [7:0]            layer_q[$];
  int                    bad_count = 0;
  bit                    calm = 1'b0;
  int                    hold_asks = 0;
  int                    hold_done = 0;
  int                    hold_left = 0;
  int                    stall_left = 0;

  rle_count_symbol_parser dut (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .data_byte  (data_byte),
    .layer_last (layer_last),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .run_valid  (run_valid),
    .run_count  (run_count),
    .symbol     (symbol),
    .status     (status),
    .layer_end  (layer_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic rlecsp_pkg::status_t close_run(
      input logic [rlecsp_pkg::COUNT_W-1:0] cnt, output logic ok);
    ok = 1'b0;
    parser.digit_value = '0;
    parser.digit_count = '0;
    if (cnt == 0) return rlecsp_pkg::ST_ZERO;
    if (32'(parser.run_total) + 32'(cnt) > 32'(layer_cells)) return rlecsp_pkg::ST_OVER;
    parser.run_total = 25'(32'(parser.run_total) + 32'(cnt));
    ok = 1'b1;
    return rlecsp_pkg::ST_OK;
  endfunction

  function automatic rlecsp_pkg::parse_result_t parse_char(input logic [7:0] b,
                                                           input logic last);
    rlecsp_pkg::parse_result_t r;
    logic ok;
    logic [rlecsp_pkg::COUNT_W-1:0] cnt;
    logic [rlecsp_pkg::DIGIT_W-1:0] lim;
    r = '0;
    ok = 1'b0;
    cnt = '0;
    if (parser.error_latched) begin
      if (!last) return r;
    end else if (parser.awaiting_second) begin
      cnt = parser.digit_value;
      r.symbol = {parser.first_char, b};
      parser.awaiting_second = 1'b0;
      parser.first_char = '0;
      r.status = close_run(cnt, ok);
    end else if (b >= "0" && b <= "9") begin
      lim = (digit_limit > rlecsp_pkg::DIGIT_CAP) ? rlecsp_pkg::DIGIT_CAP : digit_limit;
      if (parser.digit_count >= lim) begin
        r.status = rlecsp_pkg::ST_DIGITS;
      end else begin
        parser.digit_value = 27'(32'(parser.digit_value) * 10 + 32'(b - "0"));
        parser.digit_count = parser.digit_count + 1'b1;
      end
    end else if (!mode_sel) begin
      cnt = parser.digit_value;
      r.symbol = {8'h00, b};
      r.status = close_run(cnt, ok);
    end else begin
      parser.first_char = b;
      parser.awaiting_second = 1'b1;
      if (last) r.status = rlecsp_pkg::ST_TRUNCATED;
    end
    if (!ok) begin
      cnt = '0;
      r.symbol = '0;
    end
    r.emit = 1'b1;
    r.run_valid = ok;
    r.run_count = cnt;
    r.layer_end = last;
    if (last) begin
      if (r.status == rlecsp_pkg::ST_OK && !parser.error_latched &&
          parser.run_total != layer_cells)
        r.status = rlecsp_pkg::ST_SHORT;
      parser = '0;
    end else if (r.status != rlecsp_pkg::ST_OK) begin
      parser.error_latched = 1'b1;
      parser.digit_value = '0;
      parser.digit_count = '0;
      parser.awaiting_second = 1'b0;
      parser.first_char = '0;
    end else if (!ok) begin
      r.emit = 1'b0;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] any_symbol();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c >= "0" && c <= "9");
    return c;
  endfunction

  // count digits (none when cnt is negative), then one or two symbol chars
  function automatic void add_run(input int cnt, input int lim);
    string num;
    if (cnt >= 0) begin
      num = $sformatf("%0d", cnt);
      if (num.len() < lim && $urandom_range(0, 7) == 0) num = {"0", num};
      for (int i = 0; i < num.len(); i++) layer_q.insert(layer_q.size(), num[i]);
    end
    layer_q.insert(layer_q.size(), any_symbol());
    if (mode_sel) layer_q.insert(layer_q.size(), 8'($urandom_range(0, 255)));
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_count++;
    end
  endfunction

  task automatic drive_byte(input logic [7:0] ch, input logic last, input bit typed = 1'b0,
                            input rlecsp_pkg::parse_result_t typed_res = '0);
    int gap;
    rlecsp_pkg::parse_result_t got;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid <= 1'b1;
    data_byte <= ch;
    layer_last <= last;
    do @(posedge clk); while (src_stall);
    got = parse_char(ch, last);
    if (typed) pending_runs.insert(pending_runs.size(), typed_res);
    else if (got.emit) pending_runs.insert(pending_runs.size(), got);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    src_valid <= 1'b0;
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rlecsp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rlecsp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rlecsp_pkg::REG_SYMBOL_MODE: mode_sel = val[0];
      rlecsp_pkg::REG_LAYER_SIZE:  layer_cells = val[rlecsp_pkg::SIZE_W-1:0];
      rlecsp_pkg::REG_MAX_DIGITS:  digit_limit = val[rlecsp_pkg::DIGIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, a long hold on request, none while calm
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asks) begin
      hold_done <= hold_asks;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (calm) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      res_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    rlecsp_pkg::parse_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_runs.size() == 0) begin
        $error("result transfer with none expected: count %0d symbol %0h status %0d",
               run_count, symbol, status);
        bad_count++;
      end else begin
        want = pending_runs.pop_front();
        check_field("run_valid", 32'(want.run_valid), 32'(run_valid));
        check_field("run_count", 32'(want.run_count), 32'(run_count));
        check_field("symbol", 32'(want.symbol), 32'(symbol));
        check_field("status", 32'(want.status), 32'(status));
        check_field("layer_end", 32'(want.layer_end), 32'(layer_end));
      end
    end
  end

  initial begin
    script_row_t script[$];
    int sent;
    int lim;
    int maxc;
    int kind;
    int remain;
    int cnt;
    logic nm;
    logic [rlecsp_pkg::CFG_DATA_W-1:0] ns;
    logic [rlecsp_pkg::CFG_DATA_W-1:0] nd;

    script = '{
      // one run filling the reset layer size
      '{kind: ROW_CHAR, value: "2", default: '0},
      '{kind: ROW_CHAR, value: "5", default: '0},
      '{kind: ROW_CHAR, value: "6", default: '0},
      '{kind: ROW_CHECKED, value: "A", last: 1'b1, run_valid: 1'b1, count: 27'd256,
        sym: 16'h0041, st: rlecsp_pkg::ST_OK, default: '0},
      // fourth digit over the reset limit, then the closing byte
      '{kind: ROW_CHAR, value: "1", default: '0},
      '{kind: ROW_CHAR, value: "0", default: '0},
      '{kind: ROW_CHAR, value: "0", default: '0},
      '{kind: ROW_CHECKED, value: "0", st: rlecsp_pkg::ST_DIGITS, default: '0},
      '{kind: ROW_CHECKED, value: "x", last: 1'b1, st: rlecsp_pkg::ST_OK, default: '0},
      // symbol with no count
      '{kind: ROW_CHECKED, value: 8'h00, last: 1'b1, st: rlecsp_pkg::ST_ZERO, default: '0},
      '{kind: ROW_REG, reg_idx: rlecsp_pkg::REG_SYMBOL_MODE, value: 25'd1, default: '0},
      '{kind: ROW_REG, reg_idx: rlecsp_pkg::REG_LAYER_SIZE, value: 25'd1, default: '0},
      '{kind: ROW_REG, reg_idx: rlecsp_pkg::REG_MAX_DIGITS, value: 25'd8, default: '0},
      // digit taken as second symbol char
      '{kind: ROW_CHAR, value: "1", default: '0},
      '{kind: ROW_CHAR, value: 8'hFF, default: '0},
      '{kind: ROW_CHAR, value: "7", last: 1'b1, default: '0},
      // cut-off two-char symbol
      '{kind: ROW_CHAR, value: "5", default: '0},
      '{kind: ROW_CHAR, value: "q", last: 1'b1, default: '0},
      // over size, then latched until the end
      '{kind: ROW_CHAR, value: "2", default: '0},
      '{kind: ROW_CHAR, value: "a", default: '0},
      '{kind: ROW_CHAR, value: "b", default: '0},
      '{kind: ROW_CHAR, value: "3", last: 1'b1, default: '0},
      '{kind: ROW_REG, reg_idx: rlecsp_pkg::REG_SYMBOL_MODE, value: 25'd0, default: '0},
      '{kind: ROW_REG, reg_idx: rlecsp_pkg::REG_LAYER_SIZE, value: 25'd16777216, default: '0},
      '{kind: ROW_REG, reg_idx: rlecsp_pkg::REG_MAX_DIGITS, value: 25'd15, default: '0},
      // short total with a trailing digit, then with a run on the last byte
      '{kind: ROW_CHAR, value: "5", default: '0},
      '{kind: ROW_CHAR, value: "k", default: '0},
      '{kind: ROW_CHAR, value: "9", last: 1'b1, default: '0},
      '{kind: ROW_CHAR, value: "7", default: '0},
      '{kind: ROW_CHAR, value: "m", last: 1'b1, default: '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        drive_byte(script[i].value[7:0], script[i].last, script[i].kind == ROW_CHECKED,
                   rlecsp_pkg::parse_result_t'{emit: 1'b1, run_valid: script[i].run_valid,
                                               run_count: script[i].count,
                                               symbol: script[i].sym,
                                               status: script[i].st,
                                               layer_end: script[i].last});
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: begin nm = 1'b0; ns = 25'd256; nd = 25'd3; end
        1: begin nm = 1'b1; ns = 25'd1; nd = 25'd1; end
        2: begin nm = 1'b0; ns = 25'd16777216; nd = 25'd8; end
        3: begin nm = 1'b1; ns = 25'($urandom_range(1, 1000)); nd = 25'd15; end
        4: begin nm = 1'b0; ns = 25'($urandom_range(1, 99)); nd = 25'd0; end
        5: begin nm = 1'b1; ns = 25'd16777216; nd = 25'd8; end
        6: begin nm = 1'b0; ns = 25'($urandom_range(2, 5000)); nd = 25'd4; end
        default: begin nm = 1'b1; ns = 25'($urandom_range(1, 300)); nd = 25'd2; end
      endcase
      write_reg(rlecsp_pkg::REG_SYMBOL_MODE, 25'(nm));
      write_reg(rlecsp_pkg::REG_LAYER_SIZE, ns);
      write_reg(rlecsp_pkg::REG_MAX_DIGITS, nd);
      calm <= (ph == 2 || ph == 5);
      if (ph == 0 || ph == 4) hold_asks <= hold_asks + 1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        lim = int'((digit_limit > rlecsp_pkg::DIGIT_CAP) ? rlecsp_pkg::DIGIT_CAP
                                                          : digit_limit);
        maxc = (lim == 0) ? 0 : (lim >= 8) ? 99999999 : 10 ** lim - 1;
        kind = $urandom_range(0, 99);
        layer_q.delete();
        if (maxc == 0 || kind >= 90) begin
          // noise layer
          repeat ($urandom_range(1, 30))
            layer_q.insert(layer_q.size(),
                           $urandom_range(0, 1) ? 8'("0" + $urandom_range(0, 9))
                                                : 8'($urandom_range(0, 255)));
        end else begin
          remain = int'(layer_cells);
          while (remain > 0) begin
            cnt = $urandom_range(1, (remain < maxc) ? remain : maxc);
            add_run(cnt, lim);
            remain -= cnt;
          end
          if (kind >= 60 && kind < 70) begin
            repeat ($urandom_range(1, layer_q.size() - 1)) void'(layer_q.pop_back());
          end else if (kind >= 70 && kind < 80) begin
            layer_q[$urandom_range(0, layer_q.size() - 1)] = 8'($urandom_range(0, 255));
          end else if (kind >= 80 && kind < 85) begin
            add_run($urandom_range(1, maxc), lim);
          end else if (kind >= 85) begin
            case ($urandom_range(0, 2))
              0: add_run(-1, lim);
              1: add_run(0, lim);
              default: add_run(maxc + 1, lim);
            endcase
          end
        end
        foreach (layer_q[i]) drive_byte(layer_q[i], i == layer_q.size() - 1);
        sent += layer_q.size();
      end
    end

    src_valid <= 1'b0;
    for (int k = 0; k < 5000 && pending_runs.size() != 0; k++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (pending_runs.size() != 0) begin
      $error("%0d expected results never arrived", pending_runs.size());
      bad_count++;
    end
    if (bad_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rlecsp_pkg.sv
hw/rtl/rlecsp_step.sv
hw/rtl/rle_count_symbol_parser.sv
bench/rle_count_symbol_parser_tb.sv
